[rtl/mtt_pkg.sv]
// types, codes and result builder for the timer table
// no dependencies; used by multi_timer_table
package mtt_pkg;

  // opcodes of the request beat
  localparam logic [2:0] OP_ALLOC   = 3'd0;
  localparam logic [2:0] OP_FREE    = 3'd1;
  localparam logic [2:0] OP_INIT    = 3'd2;
  localparam logic [2:0] OP_SETTIME = 3'd3;
  localparam logic [2:0] OP_TICK    = 3'd4;

  // result kinds
  localparam logic [1:0] KIND_ALLOC  = 2'd0;
  localparam logic [1:0] KIND_ACK    = 2'd1;
  localparam logic [1:0] KIND_EXPIRY = 2'd2;
  localparam logic [1:0] KIND_QUIET  = 2'd3;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [5:0]  timer_index;
    logic [7:0]  queue_id;
    logic [7:0]  tag_byte;
    logic [31:0] timeout_ticks;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic        ok;
    logic [5:0]  entry_index;
    logic [7:0]  dest_queue;
    logic [7:0]  dest_tag;
    logic [31:0] tick_total;
    logic        last;
  } out_beat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ALLOC,
    ST_TICK,
    ST_FIN
  } state_t;

  function automatic out_beat_t make_beat(
    input logic [1:0]  kind,
    input logic        ok,
    input logic [5:0]  idx,
    input logic [7:0]  q,
    input logic [7:0]  t,
    input logic [31:0] total,
    input logic        last
  );
    out_beat_t b;
    b.kind        = kind;
    b.ok          = ok;
    b.entry_index = idx;
    b.dest_queue  = q;
    b.dest_tag    = t;
    b.tick_total  = total;
    b.last        = last;
    return b;
  endfunction

endpackage

[rtl/mtt_ram.sv]
// generic single write port ram with registered, enabled read
// no dependencies
module mtt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic                             re,
  input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, data held while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/multi_timer_table.sv]
// multi_timer_table: table of countdown timers with alloc, free, init, settime, tick
// depends on mtt_pkg and mtt_ram
//
//   channel | ports                          | beat
//   request | in_valid, in_stall, in_data    | in_beat_t, one per operation
//   result  | out_valid, out_stall, out_data | out_beat_t, last marks final result
//
// one operation at a time; free, init, settime and unused codes go straight to the final result,
// alloc scans the status bits for the lowest free entry before its result,
// tick walks one entry a cycle through the remaining-count ram port while no expiry waits
// on a stalled result register; such a wait holds the walk.
// reset clears status bits and tick count at once, no clearing pass.
// results leave through one output register; out_stall holds it and the walk behind it.
module multi_timer_table
  import mtt_pkg::*;
#(
  parameter int NUM_TIMERS = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_beat_t out_data
);

  localparam int AW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam logic [AW-1:0] LAST_IDX = AW'(NUM_TIMERS - 1);

  // control and status registers
  state_t                  state_r, state_nxt;
  logic [NUM_TIMERS-1:0]   used_r, used_nxt;
  logic [NUM_TIMERS-1:0]   run_r, run_nxt;
  logic [31:0]             tick_cnt_r, tick_cnt_nxt;
  logic [AW-1:0]           idx_r, idx_nxt;
  logic                    issue_r, issue_nxt;
  logic                    pend_r, pend_nxt;
  logic [AW-1:0]           pidx_r, pidx_nxt;
  logic                    hold_valid_r, hold_valid_nxt;
  out_beat_t               hold_r, hold_nxt;
  out_beat_t               fin_r, fin_nxt;
  logic                    out_valid_r, out_valid_nxt;
  out_beat_t               out_r, out_nxt;

  // ram ports
  logic                    rem_we;
  logic [AW-1:0]           rem_waddr;
  logic [31:0]             rem_wdata;
  logic [31:0]             rem_rdata;
  logic                    qt_we;
  logic [15:0]             qt_rdata;
  logic                    rd_en;
  logic [AW-1:0]           rd_addr;

  // decoded request and handshake terms
  logic                    accept;
  logic                    idx_ok;
  logic [AW-1:0]           req_addr;
  logic                    out_free;
  logic                    cand_free;
  logic                    alloc_done;
  logic                    entry_run;
  logic                    expire;
  logic                    proc_ok;
  logic                    tick_done;
  logic [31:0]             rem_dec;
  out_beat_t               exp_beat;

  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && (state_r == ST_IDLE);
  assign idx_ok    = ({1'b0, in_data.timer_index} < 7'(NUM_TIMERS));
  assign req_addr  = in_data.timer_index[AW-1:0];
  assign out_free  = !out_valid_r || !out_stall;

  // alloc scan term
  assign cand_free  = !used_r[idx_r];
  assign alloc_done = cand_free || (idx_r == LAST_IDX);

  // tick walk terms for the entry whose count sits on the ram output
  assign entry_run = pend_r && run_r[pidx_r];
  assign rem_dec   = rem_rdata - 32'd1;
  assign expire    = entry_run && (rem_rdata == 32'd1);
  assign proc_ok   = !expire || !hold_valid_r || out_free;
  assign tick_done = proc_ok && !issue_r;
  assign exp_beat  = make_beat(KIND_EXPIRY, 1'b1, 6'(pidx_r), qt_rdata[15:8],
                               qt_rdata[7:0], tick_cnt_r, 1'b0);

  mtt_ram #(
    .WIDTH (32),
    .DEPTH (NUM_TIMERS)
  ) u_rem_ram (
    .clk   (clk),
    .we    (rem_we),
    .waddr (rem_waddr),
    .wdata (rem_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rem_rdata)
  );

  mtt_ram #(
    .WIDTH (16),
    .DEPTH (NUM_TIMERS)
  ) u_qt_ram (
    .clk   (clk),
    .we    (qt_we),
    .waddr (req_addr),
    .wdata ({in_data.queue_id, in_data.tag_byte}),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (qt_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_data.opcode == OP_ALLOC) begin
            state_nxt = ST_ALLOC;
          end else if (in_data.opcode == OP_TICK) begin
            state_nxt = ST_TICK;
          end else begin
            state_nxt = ST_FIN;
          end
        end
      end
      ST_ALLOC: begin
        if (alloc_done) begin
          state_nxt = ST_FIN;
        end
      end
      ST_TICK: begin
        if (tick_done) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    used_nxt       = used_r;
    run_nxt        = run_r;
    tick_cnt_nxt   = tick_cnt_r;
    idx_nxt        = idx_r;
    issue_nxt      = issue_r;
    pend_nxt       = pend_r;
    pidx_nxt       = pidx_r;
    hold_valid_nxt = hold_valid_r;
    hold_nxt       = hold_r;
    fin_nxt        = fin_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_nxt        = out_r;
    rem_we         = 1'b0;
    rem_waddr      = req_addr;
    rem_wdata      = in_data.timeout_ticks;
    qt_we          = 1'b0;
    rd_en          = 1'b0;
    rd_addr        = idx_r;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          idx_nxt        = '0;
          issue_nxt      = 1'b1;
          pend_nxt       = 1'b0;
          hold_valid_nxt = 1'b0;
          fin_nxt        = make_beat(KIND_ACK, 1'b1, 6'd0, 8'd0, 8'd0, tick_cnt_r, 1'b1);
          unique case (in_data.opcode)
            OP_FREE: begin
              if (idx_ok) begin
                used_nxt[req_addr] = 1'b0;
                run_nxt[req_addr]  = 1'b0;
              end
            end
            OP_INIT: begin
              qt_we = idx_ok;
            end
            OP_SETTIME: begin
              if (idx_ok) begin
                rem_we             = 1'b1;
                used_nxt[req_addr] = 1'b1;
                run_nxt[req_addr]  = 1'b1;
              end
            end
            OP_TICK: begin
              tick_cnt_nxt = tick_cnt_r + 32'd1;
            end
            default: begin
            end
          endcase
        end
      end

      // lowest free entry, one status bit a cycle
      ST_ALLOC: begin
        if (cand_free) begin
          used_nxt[idx_r] = 1'b1;
          fin_nxt = make_beat(KIND_ALLOC, 1'b1, 6'(idx_r), 8'd0, 8'd0, tick_cnt_r, 1'b1);
        end else if (idx_r == LAST_IDX) begin
          fin_nxt = make_beat(KIND_ALLOC, 1'b0, 6'd0, 8'd0, 8'd0, tick_cnt_r, 1'b1);
        end else begin
          idx_nxt = idx_r + AW'(1);
        end
      end

      // read one entry, decrement and write back the one read before it
      ST_TICK: begin
        if (proc_ok) begin
          if (entry_run) begin
            rem_we    = 1'b1;
            rem_waddr = pidx_r;
            rem_wdata = rem_dec;
          end
          // expiries wait one slot so the final one can carry last
          if (expire) begin
            run_nxt[pidx_r] = 1'b0;
            if (hold_valid_r) begin
              out_valid_nxt = 1'b1;
              out_nxt       = hold_r;
            end
            hold_valid_nxt = 1'b1;
            hold_nxt       = exp_beat;
          end
          if (issue_r) begin
            rd_en    = 1'b1;
            pend_nxt = 1'b1;
            pidx_nxt = idx_r;
            if (idx_r == LAST_IDX) begin
              issue_nxt = 1'b0;
            end else begin
              idx_nxt = idx_r + AW'(1);
            end
          end else begin
            pend_nxt = 1'b0;
          end
          if (tick_done) begin
            if (expire) begin
              fin_nxt      = exp_beat;
              fin_nxt.last = 1'b1;
            end else if (hold_valid_r) begin
              fin_nxt      = hold_r;
              fin_nxt.last = 1'b1;
            end else begin
              fin_nxt = make_beat(KIND_QUIET, 1'b1, 6'd0, 8'd0, 8'd0, tick_cnt_r, 1'b1);
            end
          end
        end
      end

      // final result beat of the operation
      ST_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_nxt       = fin_r;
        end
      end

      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      used_r       <= '0;
      run_r        <= '0;
      tick_cnt_r   <= '0;
      issue_r      <= 1'b0;
      pend_r       <= 1'b0;
      hold_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      used_r       <= used_nxt;
      run_r        <= run_nxt;
      tick_cnt_r   <= tick_cnt_nxt;
      issue_r      <= issue_nxt;
      pend_r       <= pend_nxt;
      hold_valid_r <= hold_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    pidx_r <= pidx_nxt;
    hold_r <= hold_nxt;
    fin_r  <= fin_nxt;
    out_r  <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

[bench/testbench.sv]
// self-checking bench for multi_timer_table: directed and random operation beats
// with an in-bench table predictor; needs mtt_pkg and the multi_timer_table rtl
module testbench
  import mtt_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TIMERS      = 64;
  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;

  // entry states of the predictor
  localparam logic [1:0] SLOT_FREE = 2'd0;
  localparam logic [1:0] SLOT_HELD = 2'd1;
  localparam logic [1:0] SLOT_RUN  = 2'd2;

  // opcodes with no operation behind them
  localparam logic [2:0] OP_SPARE_A = 3'd5;
  localparam logic [2:0] OP_SPARE_B = 3'd6;
  localparam logic [2:0] OP_SPARE_C = 3'd7;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_beat_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_beat_t out_data;

  // predicted timer table
  logic [1:0]  slot_state [TIMERS];
  logic [31:0] slot_left  [TIMERS];
  logic [7:0]  slot_queue [TIMERS];
  logic [7:0]  slot_tag   [TIMERS];
  logic [31:0] tick_now;
  out_beat_t   due_results[$];

  // stimulus side
  in_beat_t op_backlog[$];
  bit       slot_named [TIMERS];
  int       ops_posted = 0;
  int       ops_shown = 0;
  int       ops_taken = 0;
  int       send_idle_pct = 0;
  int       stall_pct = 0;
  int       hold_req = 0;
  int       hold_done = 0;

  // bookkeeping
  int mismatches = 0;
  int results_seen = 0;
  int expiries = 0;
  int refused = 0;
  int quiet_cycles = 0;

  multi_timer_table #(.NUM_TIMERS(TIMERS)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // apply one operation to the table and queue the result beats it causes
  function automatic void advance_table(input in_beat_t op);
    out_beat_t beat;
    out_beat_t held;
    logic      have_held;
    logic      found;
    if (op.opcode == OP_TICK) tick_now = tick_now + 32'd1;
    beat = '0;
    beat.ok = 1'b1;
    beat.last = 1'b1;
    beat.tick_total = tick_now;
    held = beat;
    have_held = 1'b0;
    found = 1'b0;
    // a 6-bit index always lands inside the 64-entry table
    case (op.opcode)
      OP_ALLOC: begin
        beat.kind = KIND_ALLOC;
        for (int i = 0; i < TIMERS; i++) begin
          if (!found && slot_state[i] == SLOT_FREE) begin
            slot_state[i] = SLOT_HELD;
            beat.entry_index = 6'(i);
            found = 1'b1;
          end
        end
        beat.ok = found;
      end
      OP_FREE: begin
        beat.kind = KIND_ACK;
        slot_state[op.timer_index] = SLOT_FREE;
      end
      OP_INIT: begin
        beat.kind = KIND_ACK;
        slot_queue[op.timer_index] = op.queue_id;
        slot_tag[op.timer_index] = op.tag_byte;
      end
      OP_SETTIME: begin
        beat.kind = KIND_ACK;
        slot_left[op.timer_index] = op.timeout_ticks;
        slot_state[op.timer_index] = SLOT_RUN;
      end
      OP_TICK: begin
        beat.kind = KIND_QUIET;
        // walk in index order; each beat is pushed once the next one is known
        for (int i = 0; i < TIMERS; i++) begin
          if (slot_state[i] == SLOT_RUN) begin
            slot_left[i] = slot_left[i] - 32'd1;
            if (slot_left[i] == 32'd0) begin
              slot_state[i] = SLOT_HELD;
              if (have_held) due_results.push_back(held);
              held = beat;
              held.kind = KIND_EXPIRY;
              held.entry_index = 6'(i);
              held.dest_queue = slot_queue[i];
              held.dest_tag = slot_tag[i];
              held.last = 1'b0;
              have_held = 1'b1;
            end
          end
        end
        if (have_held) begin
          held.last = 1'b1;
          beat = held;
        end
      end
      default: begin
        beat.kind = KIND_ACK;
      end
    endcase
    due_results.push_back(beat);
  endfunction

  task automatic check_field(input string field, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", field, want, got);
      mismatches++;
    end
  endtask

  task automatic post_op(input logic [2:0] code, input int idx, input logic [7:0] q,
                         input logic [7:0] t, input logic [31:0] ticks);
    in_beat_t b;
    b.opcode = code;
    b.timer_index = 6'(idx);
    b.queue_id = q;
    b.tag_byte = t;
    b.timeout_ticks = ticks;
    if (code == OP_INIT) slot_named[idx] = 1'b1;
    op_backlog.push_back(b);
    ops_posted++;
  endtask

  // tick with random content in the fields it ignores
  task automatic post_tick();
    post_op(OP_TICK, $urandom_range(0, TIMERS - 1), 8'($urandom), 8'($urandom), $urandom);
  endtask

  // arm-and-tick sequences in 45 of 100 picks, the rest alloc/free traffic, bare ticks and noise
  task automatic post_random(input int count);
    int         stop_at;
    int         pick;
    int         idx;
    logic [2:0] code;
    stop_at = ops_posted + count;
    while (ops_posted < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        repeat ($urandom_range(1, 4)) begin
          idx = $urandom_range(0, TIMERS - 1);
          if (!slot_named[idx] || $urandom_range(0, 1) == 1)
            post_op(OP_INIT, idx, 8'($urandom), 8'($urandom), $urandom);
          post_op(OP_SETTIME, idx, 8'($urandom), 8'($urandom), $urandom_range(1, 5));
        end
        repeat ($urandom_range(1, 6)) post_tick();
      end else if (pick < 65) begin
        repeat ($urandom_range(1, 3))
          post_op(OP_ALLOC, $urandom_range(0, TIMERS - 1), 8'($urandom), 8'($urandom),
                  $urandom);
        repeat ($urandom_range(1, 2))
          post_op(OP_FREE, $urandom_range(0, TIMERS - 1), 8'($urandom), 8'($urandom),
                  $urandom);
      end else if (pick < 80) begin
        repeat ($urandom_range(1, 2)) post_tick();
      end else begin
        code = 3'($urandom_range(0, 7));
        idx = $urandom_range(0, TIMERS - 1);
        // never start an entry whose queue id and tag were never stored
        if (code == OP_SETTIME && !slot_named[idx]) code = OP_INIT;
        post_op(code, idx, 8'($urandom), 8'($urandom), $urandom);
      end
    end
  endtask

  // wait until every posted beat is taken and every result has come back
  task automatic drain();
    do @(negedge clk);
    while (ops_taken != ops_posted || due_results.size() != 0);
    @(posedge clk);
  endtask

  // sender: valid holds with an unchanged payload until the beat is taken
  always @(negedge clk) begin
    in_beat_t beat;
    beat = in_data;
    if (rst_n && ops_taken == ops_shown && op_backlog.size() > 0 &&
        $urandom_range(0, 99) >= send_idle_pct) begin
      beat = op_backlog.pop_front();
      ops_shown++;
      in_data <= beat;
    end
    in_valid <= (ops_taken != ops_shown);
  end

  // receiver: requested hold-off first, then random stalls
  always @(negedge clk) begin
    if (hold_done < hold_req) begin
      out_stall <= 1'b1;
      hold_done++;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // accept beats on both channels, predict and compare; watchdog last
  always @(posedge clk) begin
    out_beat_t want;
    if (!rst_n) begin
      for (int i = 0; i < TIMERS; i++) begin
        slot_state[i] = SLOT_FREE;
        slot_left[i] = '0;
        slot_queue[i] = '0;
        slot_tag[i] = '0;
      end
      tick_now = '0;
    end else begin
      quiet_cycles++;
      if (in_valid && !in_stall) begin
        advance_table(in_data);
        ops_taken++;
        quiet_cycles = 0;
      end
      if (out_valid && !out_stall) begin
        quiet_cycles = 0;
        results_seen++;
        if (out_data.kind == KIND_EXPIRY) expiries++;
        if (out_data.kind == KIND_ALLOC && !out_data.ok) refused++;
        if (due_results.size() == 0) begin
          $error("result beat with nothing expected: %h", out_data);
          mismatches++;
        end else begin
          want = due_results.pop_front();
          check_field("kind", 32'(want.kind), 32'(out_data.kind));
          check_field("ok", 32'(want.ok), 32'(out_data.ok));
          check_field("entry_index", 32'(want.entry_index), 32'(out_data.entry_index));
          check_field("dest_queue", 32'(want.dest_queue), 32'(out_data.dest_queue));
          check_field("dest_tag", 32'(want.dest_tag), 32'(out_data.dest_tag));
          check_field("tick_total", want.tick_total, out_data.tick_total);
          check_field("last", 32'(want.last), 32'(out_data.last));
        end
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no beat moved for %0d cycles", QUIET_LIMIT);
        $display("multi_timer_table: mismatch");
        $finish;
      end
    end
  end

  initial begin
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // no idling; a long receiver hold-off backs the table up while directed beats wait
    send_idle_pct = 0;
    stall_pct = 0;
    hold_req = HOLD_CYCLES;
    post_op(OP_ALLOC, 0, 8'h00, 8'h00, 32'h0);
    post_op(OP_ALLOC, 63, 8'hff, 8'hff, 32'hffff_ffff);
    post_op(OP_INIT, 0, 8'hff, 8'h00, 32'h0);
    // init and settime of a free entry
    post_op(OP_INIT, 63, 8'h00, 8'hff, 32'h0);
    post_op(OP_INIT, 1, 8'ha5, 8'h5a, 32'h0);
    post_op(OP_SETTIME, 0, 8'h00, 8'h00, 32'd1);
    post_op(OP_SETTIME, 63, 8'h00, 8'h00, 32'd2);
    // zero timeout wraps instead of firing
    post_op(OP_SETTIME, 1, 8'h00, 8'h00, 32'd0);
    post_tick();
    post_tick();
    post_tick();
    // free a running entry, then alloc picks it up again
    post_op(OP_FREE, 1, 8'h00, 8'h00, 32'h0);
    post_op(OP_ALLOC, 0, 8'h00, 8'h00, 32'h0);
    post_op(OP_SETTIME, 63, 8'hff, 8'hff, 32'hffff_ffff);
    post_op(OP_FREE, 63, 8'hff, 8'hff, 32'hffff_ffff);
    // freed entry is skipped by the tick walk
    post_op(OP_SETTIME, 0, 8'h00, 8'h00, 32'd1);
    post_op(OP_FREE, 0, 8'h00, 8'h00, 32'h0);
    post_tick();
    post_op(OP_SPARE_A, 63, 8'hff, 8'hff, 32'hffff_ffff);
    post_op(OP_SPARE_B, 0, 8'h00, 8'h00, 32'h0);
    post_op(OP_SPARE_C, 42, 8'h5a, 8'ha5, 32'h5555_aaaa);
    // two entries firing on the same tick
    post_op(OP_SETTIME, 0, 8'h00, 8'h00, 32'd2);
    post_op(OP_SETTIME, 1, 8'h00, 8'h00, 32'd2);
    post_tick();
    post_tick();
    drain();

    // sender mostly idle
    send_idle_pct = 79;
    post_random(60);
    drain();

    // receiver mostly stalling: whole table fires on one tick, then alloc finds nothing free
    send_idle_pct = 0;
    stall_pct = 79;
    for (int k = 0; k < TIMERS; k++)
      post_op(OP_INIT, k, 8'($urandom), 8'($urandom), $urandom);
    for (int k = 0; k < TIMERS; k++)
      post_op(OP_SETTIME, k, 8'($urandom), 8'($urandom), 32'd1);
    post_tick();
    post_op(OP_ALLOC, $urandom_range(0, TIMERS - 1), 8'($urandom), 8'($urandom), $urandom);
    post_random(30);
    drain();

    // light idling on both sides
    send_idle_pct = 14;
    stall_pct = 14;
    post_random(60);
    drain();

    // tail: catch any stray result beats
    stall_pct = 0;
    repeat (150) @(posedge clk);

    $display("covered %0d operations, %0d result beats: %0d expiries, %0d refused allocs",
             ops_taken, results_seen, expiries, refused);
    $display("idling phases: none with a %0d-cycle hold-off, sender, receiver, both",
             HOLD_CYCLES);
    if (mismatches == 0)
      $display("multi_timer_table: match");
    else
      $display("multi_timer_table: mismatch");
    $finish;
  end

endmodule

[multi_timer_table.f]
rtl/mtt_pkg.sv
rtl/mtt_ram.sv
rtl/multi_timer_table.sv
bench/testbench.sv
